@@ src/vnrp_pkg.sv @@
package vnrp_pkg;

    localparam int MAX_DIM             = 64;
    localparam int BACKING_TAPS        = 6;
    localparam int BACKING_REACH_CELLS = 3;
    localparam int CAVITY_TAPS         = 8;
    localparam int CAVITY_MAX_CELLS    = 4;

    // quotient bits of one axis index, and the step counter of the divider
    localparam int QW         = $clog2(MAX_DIM);
    localparam int CNT_W      = $clog2(QW + 1);
    localparam int GRID_CELLS = MAX_DIM * MAX_DIM * MAX_DIM;
    localparam int ADDR_W     = $clog2(GRID_CELLS);

    localparam int MAX_TAPS = (BACKING_TAPS > CAVITY_TAPS) ? BACKING_TAPS : CAVITY_TAPS;
    localparam int MAX_REACH = (BACKING_REACH_CELLS > CAVITY_MAX_CELLS) ?
                               BACKING_REACH_CELLS : CAVITY_MAX_CELLS;
    localparam int TAP_W   = $clog2(MAX_TAPS + 1);
    localparam int REACH_W = $clog2(MAX_REACH + 1);

    // den = cell_size * taps * 2^14, lim = den * 2^QW
    localparam int DEN_W = 16 + TAP_W + 14;
    localparam int LIM_W = DEN_W + QW;
    // (c - o) * taps * 2^14 - n * reach * t * cell_size, with headroom
    localparam int NUM_W = 34 + TAP_W + 14 + 2;

    localparam int DIM_W     = 7;
    localparam int DIM_CMP_W = 9;
    localparam int DEPTH_W   = 11;
    localparam int DEPTH_MAX = 2047;

    typedef enum logic
    {
        OP_WRITE = 1'b0,
        OP_PROBE = 1'b1
    } op_t;

    localparam logic [2:0] REG_ORIGIN_X  = 3'd0;
    localparam logic [2:0] REG_ORIGIN_Y  = 3'd1;
    localparam logic [2:0] REG_ORIGIN_Z  = 3'd2;
    localparam logic [2:0] REG_CELL_SIZE = 3'd3;
    localparam logic [2:0] REG_DIMS_X    = 3'd4;
    localparam logic [2:0] REG_DIMS_Y    = 3'd5;
    localparam logic [2:0] REG_DIMS_Z    = 3'd6;
    localparam logic [2:0] REG_ISO_LEVEL = 3'd7;

    typedef struct packed
    {
        logic          done;
        logic [QW-1:0] quo;
    } div_stat_t;

    function automatic logic [ADDR_W-1:0] grid_addr(input logic [QW-1:0] x,
                                                    input logic [QW-1:0] y,
                                                    input logic [QW-1:0] z);
        return ADDR_W'(x) + ADDR_W'(MAX_DIM) * (ADDR_W'(y) + ADDR_W'(MAX_DIM) * ADDR_W'(z));
    endfunction

    function automatic logic [DIM_CMP_W-1:0] dim_used(input logic [DIM_W-1:0] d);
        return (int'(d) > MAX_DIM) ? DIM_CMP_W'(MAX_DIM) : DIM_CMP_W'(d);
    endfunction

    function automatic logic [DEPTH_W-1:0] depth_clip(input int v);
        return (v > DEPTH_MAX) ? DEPTH_W'(DEPTH_MAX) : DEPTH_W'(v);
    endfunction

    function automatic logic [DEPTH_W-1:0] depth_of(input logic [TAP_W-1:0] hits);
        int v;
        v = (CAVITY_MAX_CELLS * 256 * int'(hits)) / CAVITY_TAPS;
        return depth_clip(v);
    endfunction

endpackage

@@ src/voxel_normal_ray_probe.sv @@
// channel   dir  handshake            payload
// s_*       in   s_tvalid/s_tready    write or probe request, kind in s_tuser
// m_*       out  m_tvalid/m_tready    probe result, no_volume in m_tuser
// cfg_*     in   cfg_valid/cfg_ready  register index and data, always ready
//
// A write request writes the grid on the accepting edge.
// A probe takes 2 passes, each a setup and then, per tap, a step along the ray; for each
// axis checked it runs a division in the shared divider, then a grid read. Without a volume
// the probe goes straight to its result.
// s_tready is low from a probe's acceptance until its result sits in the output
// register; the result register holds while m_tready is low. Reset clears all
// control state; the grid is not cleared.
module voxel_normal_ray_probe import vnrp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // cell_x[5:0] cell_y[11:6] cell_z[17:12] occupancy[25:18] center_x[57:26]
    // center_y[89:58] center_z[121:90] normal_x[137:122] normal_y[153:138]
    // normal_z[169:154], zero fill to 175
    input  logic [175:0] s_tdata,
    // operation[0]
    input  logic         s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // has_backing[0] cavity_depth[11:1], zero fill to 15
    output logic [15:0]  m_tdata,
    // no_volume[0]
    output logic         m_tuser,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_SETUP,
        ST_TAP,
        ST_CHECK,
        ST_DIV,
        ST_RD,
        ST_HIT,
        ST_DONE
    } state_t;

    state_t state_reg;

    // configuration
    logic signed [31:0] origin_reg [3];
    logic [15:0]        cs_reg;
    logic [DIM_W-1:0]   dims_reg [3];
    logic [7:0]         iso_reg;

    // control
    logic             pass_reg;
    logic [1:0]       setup_cnt_reg;
    logic [1:0]       axis_reg;
    logic [TAP_W-1:0] tap_cnt_reg;
    logic [TAP_W-1:0] bhits_reg;
    logic [TAP_W-1:0] chits_reg;
    logic             nv_reg;
    logic             m_tvalid_reg;
    logic [15:0]      m_tdata_reg;
    logic             m_tuser_reg;

    // payload
    logic signed [32:0]      diff_reg [3];
    logic signed [15:0]      nrm_reg [3];
    logic signed [NUM_W-1:0] acc_reg [3];
    logic signed [NUM_W-1:0] step_reg [3];
    logic signed [32:0]      prod_reg;
    logic [DEN_W-1:0]        den_reg;
    logic [LIM_W-1:0]        lim_reg;
    logic [QW-1:0]           idx_reg [3];

    logic                    accept;
    logic                    op_probe;
    logic                    no_vol;
    logic                    wr_in_range;
    logic [5:0]              in_cell [3];
    logic [7:0]              in_occ;
    logic signed [31:0]      in_center [3];
    logic signed [15:0]      in_normal [3];
    logic [TAP_W-1:0]        taps_sel;
    logic [REACH_W-1:0]      reach_sel;
    logic [1:0]              setup_ax;
    logic [1:0]              step_ax;
    logic signed [NUM_W-1:0] base_val;
    logic signed [32:0]      prod_val;
    logic signed [NUM_W-1:0] step_val;
    logic [DEN_W-1:0]        den_val;
    logic signed [NUM_W-1:0] acc_cur;
    logic                    out_range;
    logic                    q_ok;
    logic                    out_ready;
    div_stat_t               div_stat;
    logic [7:0]              rd_data;

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign accept    = s_tvalid && s_tready;
    assign op_probe  = (op_t'(s_tuser) == OP_PROBE);

    assign in_cell[0]   = s_tdata[5:0];
    assign in_cell[1]   = s_tdata[11:6];
    assign in_cell[2]   = s_tdata[17:12];
    assign in_occ       = s_tdata[25:18];
    assign in_center[0] = s_tdata[57:26];
    assign in_center[1] = s_tdata[89:58];
    assign in_center[2] = s_tdata[121:90];
    assign in_normal[0] = s_tdata[137:122];
    assign in_normal[1] = s_tdata[153:138];
    assign in_normal[2] = s_tdata[169:154];

    assign no_vol = (cs_reg == '0) || (dims_reg[0] == '0) || (dims_reg[1] == '0)
                  || (dims_reg[2] == '0);
    assign wr_in_range = (int'(in_cell[0]) < MAX_DIM) && (int'(in_cell[1]) < MAX_DIM)
                       && (int'(in_cell[2]) < MAX_DIM);

    assign taps_sel  = pass_reg ? TAP_W'(CAVITY_TAPS) : TAP_W'(BACKING_TAPS);
    assign reach_sel = pass_reg ? REACH_W'(CAVITY_MAX_CELLS) : REACH_W'(BACKING_REACH_CELLS);

    // setup: axis k loads its base and product while axis k-1 loads its step from the registered product
    assign setup_ax = (setup_cnt_reg == 2'd3) ? 2'd0 : setup_cnt_reg;
    assign step_ax  = (setup_cnt_reg == 2'd0) ? 2'd0 : setup_cnt_reg - 2'd1;
    assign base_val = (NUM_W'(diff_reg[setup_ax]) * $signed({1'b0, taps_sel})) <<< 14;
    assign prod_val = nrm_reg[setup_ax] * $signed({1'b0, cs_reg});
    assign step_val = NUM_W'(prod_reg) * $signed({1'b0, reach_sel});
    assign den_val  = (DEN_W'(cs_reg) * DEN_W'(taps_sel)) << 14;

    assign acc_cur   = acc_reg[axis_reg];
    assign out_range = acc_cur[NUM_W-1]
                     || (acc_cur >= $signed({{(NUM_W - LIM_W){1'b0}}, lim_reg}));
    assign q_ok      = ({{(DIM_CMP_W - QW){1'b0}}, div_stat.quo} < dim_used(dims_reg[axis_reg]));
    assign out_ready = !m_tvalid_reg || m_tready;

    vnrp_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (state_reg == ST_CHECK && !out_range),
        .num   (acc_cur[LIM_W-1:0]),
        .den   (den_reg),
        .stat  (div_stat)
    );

    vnrp_grid u_grid
    (
        .clk     (clk),
        .wr_en   (accept && !op_probe && wr_in_range),
        .wr_addr (grid_addr(QW'(in_cell[0]), QW'(in_cell[1]), QW'(in_cell[2]))),
        .wr_data (in_occ),
        .rd_en   (state_reg == ST_RD),
        .rd_addr (grid_addr(idx_reg[0], idx_reg[1], idx_reg[2])),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_reg[0] <= '0;
            origin_reg[1] <= '0;
            origin_reg[2] <= '0;
            cs_reg        <= '0;
            dims_reg[0]   <= '0;
            dims_reg[1]   <= '0;
            dims_reg[2]   <= '0;
            iso_reg       <= 8'd64;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_ORIGIN_X:  origin_reg[0] <= cfg_data;
                REG_ORIGIN_Y:  origin_reg[1] <= cfg_data;
                REG_ORIGIN_Z:  origin_reg[2] <= cfg_data;
                REG_CELL_SIZE: cs_reg        <= cfg_data[15:0];
                REG_DIMS_X:    dims_reg[0]   <= cfg_data[DIM_W-1:0];
                REG_DIMS_Y:    dims_reg[1]   <= cfg_data[DIM_W-1:0];
                REG_DIMS_Z:    dims_reg[2]   <= cfg_data[DIM_W-1:0];
                REG_ISO_LEVEL: iso_reg       <= cfg_data[7:0];
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pass_reg      <= 1'b0;
            setup_cnt_reg <= '0;
            axis_reg      <= '0;
            tap_cnt_reg   <= '0;
            bhits_reg     <= '0;
            chits_reg     <= '0;
            nv_reg        <= 1'b0;
            m_tvalid_reg  <= 1'b0;
            m_tdata_reg   <= '0;
            m_tuser_reg   <= 1'b0;
        end
        else
        begin
            // in the done state the valid flag is driven there
            if (m_tready && state_reg != ST_DONE)
            begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept && op_probe)
                    begin
                        nv_reg        <= no_vol;
                        pass_reg      <= 1'b0;
                        setup_cnt_reg <= '0;
                        bhits_reg     <= '0;
                        chits_reg     <= '0;
                        state_reg     <= no_vol ? ST_DONE : ST_SETUP;
                    end
                end
                ST_SETUP:
                begin
                    setup_cnt_reg <= setup_cnt_reg + 2'd1;
                    if (setup_cnt_reg == 2'd3)
                    begin
                        tap_cnt_reg <= '0;
                        state_reg   <= ST_TAP;
                    end
                end
                ST_TAP:
                begin
                    if (tap_cnt_reg == taps_sel)
                    begin
                        if (!pass_reg)
                        begin
                            pass_reg      <= 1'b1;
                            setup_cnt_reg <= '0;
                            state_reg     <= ST_SETUP;
                        end
                        else
                        begin
                            state_reg <= ST_DONE;
                        end
                    end
                    else
                    begin
                        tap_cnt_reg <= tap_cnt_reg + 1'b1;
                        axis_reg    <= '0;
                        state_reg   <= ST_CHECK;
                    end
                end
                ST_CHECK:
                begin
                    state_reg <= out_range ? ST_TAP : ST_DIV;
                end
                ST_DIV:
                begin
                    if (div_stat.done)
                    begin
                        if (!q_ok)
                        begin
                            state_reg <= ST_TAP;
                        end
                        else if (axis_reg == 2'd2)
                        begin
                            state_reg <= ST_RD;
                        end
                        else
                        begin
                            axis_reg  <= axis_reg + 2'd1;
                            state_reg <= ST_CHECK;
                        end
                    end
                end
                ST_RD:
                begin
                    state_reg <= ST_HIT;
                end
                ST_HIT:
                begin
                    if (rd_data >= iso_reg)
                    begin
                        if (pass_reg)
                        begin
                            chits_reg <= chits_reg + 1'b1;
                        end
                        else
                        begin
                            bhits_reg <= bhits_reg + 1'b1;
                        end
                    end
                    state_reg <= ST_TAP;
                end
                ST_DONE:
                begin
                    if (out_ready)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_tuser_reg  <= nv_reg;
                        if (nv_reg)
                        begin
                            m_tdata_reg <= {4'b0, depth_clip(CAVITY_MAX_CELLS * 256), 1'b1};
                        end
                        else
                        begin
                            m_tdata_reg <= {4'b0, depth_of(chits_reg), (bhits_reg != '0)};
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && op_probe)
        begin
            for (int a = 0; a < 3; a++)
            begin
                diff_reg[a] <= 33'(in_center[a]) - 33'(origin_reg[a]);
                nrm_reg[a]  <= in_normal[a];
            end
        end
        if (state_reg == ST_SETUP)
        begin
            if (setup_cnt_reg != 2'd3)
            begin
                prod_reg          <= prod_val;
                acc_reg[setup_ax] <= base_val;
            end
            if (setup_cnt_reg != 2'd0)
            begin
                step_reg[step_ax] <= step_val;
            end
            if (setup_cnt_reg == 2'd0)
            begin
                den_reg <= den_val;
            end
            if (setup_cnt_reg == 2'd1)
            begin
                lim_reg <= LIM_W'(den_reg) << QW;
            end
        end
        if (state_reg == ST_TAP && tap_cnt_reg != taps_sel)
        begin
            for (int a = 0; a < 3; a++)
            begin
                acc_reg[a] <= acc_reg[a] - step_reg[a];
            end
        end
        if (state_reg == ST_DIV && div_stat.done)
        begin
            idx_reg[axis_reg] <= div_stat.quo;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(state_reg == ST_DONE))
        else $error("result raised outside the done state");

    a_novol_default: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |->
        (m_tdata[0] && m_tdata[11:1] == depth_clip(CAVITY_MAX_CELLS * 256)))
        else $error("no-volume result carries a wrong answer");

    a_read_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RD) |->
        ({{(DIM_CMP_W - QW){1'b0}}, idx_reg[0]} < dim_used(dims_reg[0])) &&
        ({{(DIM_CMP_W - QW){1'b0}}, idx_reg[1]} < dim_used(dims_reg[1])) &&
        ({{(DIM_CMP_W - QW){1'b0}}, idx_reg[2]} < dim_used(dims_reg[2])))
        else $error("grid read outside the volume in use");

    a_tap_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_TAP || state_reg == ST_CHECK || state_reg == ST_DIV
         || state_reg == ST_RD || state_reg == ST_HIT) |-> (tap_cnt_reg <= taps_sel))
        else $error("tap counter past the pass length");

endmodule

@@ src/vnrp_grid.sv @@
module vnrp_grid import vnrp_pkg::*;
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [7:0]        wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [7:0]        rd_data
);

    logic [7:0] mem [GRID_CELLS];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ src/vnrp_div.sv @@
module vnrp_div import vnrp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [LIM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output div_stat_t        stat
);

    // restoring divider, one quotient bit a cycle; num < den * 2^QW on start
    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [LIM_W-1:0] rem_reg;
    logic [LIM_W-1:0] dsh_reg;
    logic [QW-1:0]    quo_reg;
    logic [LIM_W:0]   trial;
    logic             ge;

    assign trial = {1'b0, rem_reg} - {1'b0, dsh_reg};
    assign ge    = !trial[LIM_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(QW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= num;
            dsh_reg <= LIM_W'(den) << (QW - 1);
        end
        else if (busy_reg)
        begin
            if (ge)
            begin
                rem_reg <= trial[LIM_W-1:0];
            end
            dsh_reg <= dsh_reg >> 1;
            quo_reg <= QW'({quo_reg, ge});
        end
    end

    assign stat.done = done_reg;
    assign stat.quo  = quo_reg;

endmodule

@@ tb/vnrp_result_checker.sv @@
`timescale 1ns / 1ps

module vnrp_result_checker import vnrp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [175:0] s_tdata,
    input  logic         s_tuser,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [15:0]  m_tdata,
    input  logic         m_tuser,
    input  logic         cfg_valid,
    input  logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data,
    output int           fails,
    output int           pending,
    output int           probes_done
);

    typedef struct packed
    {
        logic               backing;
        logic [DEPTH_W-1:0] depth;
        logic               no_vol;
    } probe_answer_t;

    probe_answer_t answers_due[$];

    logic [7:0]  grid [0:GRID_CELLS-1];
    logic [31:0] org_x, org_y, org_z;
    logic [15:0] cell_edge;
    logic [6:0]  dim_x, dim_y, dim_z;
    logic [7:0]  iso;

    function automatic longint floor_quot(longint a, longint b);
        longint q;
        q = a / b;
        if ((a % b) != 0 && a < 0)
            q = q - 1;
        return q;
    endfunction

    function automatic longint cap_dim(logic [6:0] d);
        return (d > MAX_DIM) ? MAX_DIM : longint'(d);
    endfunction

    // count taps along the reversed normal that land on solid cells
    function automatic int count_solid_taps(longint cen[3], longint nrm[3],
                                            longint taps, longint reach);
        longint orgv[3];
        longint dimv[3];
        longint cs;
        longint den;
        longint idx[3];
        int     hits;
        bit     in_grid;
        orgv[0] = longint'($signed(org_x));
        orgv[1] = longint'($signed(org_y));
        orgv[2] = longint'($signed(org_z));
        dimv[0] = cap_dim(dim_x);
        dimv[1] = cap_dim(dim_y);
        dimv[2] = cap_dim(dim_z);
        cs = longint'(cell_edge);
        den = cs * taps * 16384;
        hits = 0;
        for (longint t = 1; t <= taps; t++)
        begin
            in_grid = 1;
            for (int a = 0; a < 3; a++)
            begin
                idx[a] = floor_quot((cen[a] - orgv[a]) * taps * 16384
                                    - nrm[a] * reach * t * cs, den);
                if (idx[a] < 0 || idx[a] >= dimv[a])
                    in_grid = 0;
            end
            if (in_grid && grid[idx[0] + MAX_DIM * (idx[1] + MAX_DIM * idx[2])] >= iso)
                hits++;
        end
        return hits;
    endfunction

    function automatic probe_answer_t predict_probe(logic [175:0] d);
        probe_answer_t r;
        longint cen[3];
        longint nrm[3];
        int     back_hits;
        int     cav_hits;
        int     dep;
        if (cell_edge == 0 || dim_x == 0 || dim_y == 0 || dim_z == 0)
        begin
            dep = CAVITY_MAX_CELLS * 256;
            r.backing = 1'b1;
            r.depth = (dep > DEPTH_MAX) ? DEPTH_W'(DEPTH_MAX) : DEPTH_W'(dep);
            r.no_vol = 1'b1;
            return r;
        end
        cen[0] = longint'($signed(d[57:26]));
        cen[1] = longint'($signed(d[89:58]));
        cen[2] = longint'($signed(d[121:90]));
        nrm[0] = longint'($signed(d[137:122]));
        nrm[1] = longint'($signed(d[153:138]));
        nrm[2] = longint'($signed(d[169:154]));
        back_hits = count_solid_taps(cen, nrm, BACKING_TAPS, BACKING_REACH_CELLS);
        cav_hits = count_solid_taps(cen, nrm, CAVITY_TAPS, CAVITY_MAX_CELLS);
        dep = (CAVITY_MAX_CELLS * 256 * cav_hits) / CAVITY_TAPS;
        r.backing = (back_hits > 0);
        r.depth = (dep > DEPTH_MAX) ? DEPTH_W'(DEPTH_MAX) : DEPTH_W'(dep);
        r.no_vol = 1'b0;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
        fails++;
    endtask

    initial
    begin
        fails = 0;
        pending = 0;
        probes_done = 0;
        org_x = 0;
        org_y = 0;
        org_z = 0;
        cell_edge = 0;
        dim_x = 0;
        dim_y = 0;
        dim_z = 0;
        iso = 8'd64;
    end

    always @(posedge clk)
    begin
        probe_answer_t want;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_ORIGIN_X:  org_x = cfg_data;
                    REG_ORIGIN_Y:  org_y = cfg_data;
                    REG_ORIGIN_Z:  org_z = cfg_data;
                    REG_CELL_SIZE: cell_edge = cfg_data[15:0];
                    REG_DIMS_X:    dim_x = cfg_data[6:0];
                    REG_DIMS_Y:    dim_y = cfg_data[6:0];
                    REG_DIMS_Z:    dim_z = cfg_data[6:0];
                    REG_ISO_LEVEL: iso = cfg_data[7:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
            begin
                if (op_t'(s_tuser) == OP_WRITE)
                    grid[grid_addr(s_tdata[5:0], s_tdata[11:6], s_tdata[17:12])]
                        = s_tdata[25:18];
                else
                    answers_due.push_back(predict_probe(s_tdata));
            end
            if (m_tvalid && m_tready)
            begin
                probes_done++;
                if (answers_due.size() == 0)
                begin
                    report_mismatch("unexpected result", 1, 0);
                end
                else
                begin
                    want = answers_due.pop_front();
                    if (m_tdata[0] != want.backing)
                        report_mismatch("has_backing", m_tdata[0], want.backing);
                    if (m_tdata[11:1] != want.depth)
                        report_mismatch("cavity_depth", m_tdata[11:1], want.depth);
                    if (m_tuser != want.no_vol)
                        report_mismatch("no_volume", m_tuser, want.no_vol);
                    if (m_tdata[15:12] != 0)
                        report_mismatch("fill bits", m_tdata[15:12], 0);
                end
            end
            pending = answers_due.size();
        end
    end

endmodule

@@ tb/voxel_normal_ray_probe_tb.sv @@
`timescale 1ns / 1ps

module voxel_normal_ray_probe_tb import vnrp_pkg::*;
();

    localparam int CYCLE_LIMIT = 3000000;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [175:0] s_tdata;
    logic         s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [15:0]  m_tdata;
    logic         m_tuser;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [2:0]   cfg_index;
    logic [31:0]  cfg_data;

    int fails;
    int pending;
    int probes_done;
    int cycles;
    int requests_sent;

    // knobs for the result and request sides
    bit sink_steady;
    bit sink_hold_req;
    bit src_steady;

    // current grid setup, used to aim probes
    logic [31:0] cur_org [3];
    logic [15:0] cur_edge;
    int          cur_dim [3];
    logic [7:0]  cur_iso;

    voxel_normal_ray_probe dut
    (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    vnrp_result_checker chk
    (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .fails(fails), .pending(pending), .probes_done(probes_done)
    );

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        m_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        cycles = 0;
        requests_sent = 0;
        sink_steady = 0;
        sink_hold_req = 0;
        src_steady = 0;
    end

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // result side: random stall bursts, one long hold-off on request
    initial
    begin
        int gap;
        int hold;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (sink_hold_req)
            begin
                sink_hold_req = 0;
                m_tready <= 1'b0;
                hold = 0;
                while (hold < 2000)
                begin
                    @(posedge clk);
                    hold++;
                end
                m_tready <= 1'b1;
            end
            else if (!sink_steady && $urandom_range(0, 9) == 0)
            begin
                gap = $urandom_range(1, 18);
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
                m_tready <= 1'b1;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic send_request(input op_t op, input logic [175:0] payload);
        int gap;
        if (!src_steady && $urandom_range(0, 9) == 0)
        begin
            gap = $urandom_range(1, 18);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= payload;
        do
            @(posedge clk);
        while (!s_tready);
        requests_sent++;
    endtask

    task automatic write_cell(input int x, input int y, input int z, input logic [7:0] occ);
        logic [175:0] p;
        p = '0;
        p[5:0] = x;
        p[11:6] = y;
        p[17:12] = z;
        p[25:18] = occ;
        send_request(OP_WRITE, p);
    endtask

    task automatic probe_at(input logic [31:0] cx, input logic [31:0] cy, input logic [31:0] cz,
                            input logic [15:0] nx, input logic [15:0] ny, input logic [15:0] nz);
        logic [175:0] p;
        p = '0;
        p[57:26] = cx;
        p[89:58] = cy;
        p[121:90] = cz;
        p[137:122] = nx;
        p[153:138] = ny;
        p[169:154] = nz;
        send_request(OP_PROBE, p);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        // let the checker log the last accepted request first
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        // a trailing write may still be in flight
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    task automatic set_grid(input logic [31:0] ox, input logic [31:0] oy, input logic [31:0] oz,
                            input logic [15:0] edge_len, input int dx, input int dy,
                            input int dz, input logic [7:0] lvl);
        wait_idle();
        write_reg(REG_ORIGIN_X, ox);
        write_reg(REG_ORIGIN_Y, oy);
        write_reg(REG_ORIGIN_Z, oz);
        write_reg(REG_CELL_SIZE, {16'h0, edge_len});
        write_reg(REG_DIMS_X, dx);
        write_reg(REG_DIMS_Y, dy);
        write_reg(REG_DIMS_Z, dz);
        write_reg(REG_ISO_LEVEL, {24'h0, lvl});
        cfg_valid <= 1'b0;
        cur_org[0] = ox;
        cur_org[1] = oy;
        cur_org[2] = oz;
        cur_edge = edge_len;
        cur_dim[0] = (dx > MAX_DIM) ? MAX_DIM : dx;
        cur_dim[1] = (dy > MAX_DIM) ? MAX_DIM : dy;
        cur_dim[2] = (dz > MAX_DIM) ? MAX_DIM : dz;
        cur_iso = lvl;
        // every cell a probe may read gets written before probing
        for (int z = 0; z < cur_dim[2]; z++)
            for (int y = 0; y < cur_dim[1]; y++)
                for (int x = 0; x < cur_dim[0]; x++)
                    write_cell(x, y, z, ($urandom_range(0, 3) == 0) ? lvl
                                                                     : 8'($urandom));
    endtask

    function automatic logic [15:0] pick_normal_axis();
        case ($urandom_range(0, 4))
            0: return 16'sd16384;
            1: return -16'sd16384;
            2: return 16'd0;
            default: return 16'($signed($urandom_range(0, 32768)) - 16384);
        endcase
    endfunction

    task automatic random_traffic(input int count);
        logic [31:0] c [3];
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                if ($urandom_range(0, 1) == 0 && cur_dim[0] > 0 && cur_dim[1] > 0
                    && cur_dim[2] > 0)
                    write_cell($urandom_range(0, cur_dim[0] - 1), $urandom_range(0, cur_dim[1] - 1),
                               $urandom_range(0, cur_dim[2] - 1), 8'($urandom));
                else
                    write_cell($urandom_range(0, 63), $urandom_range(0, 63),
                               $urandom_range(0, 63), 8'($urandom));
            end
            else if ($urandom_range(0, 6) == 0)
            begin
                probe_at($urandom, $urandom, $urandom, 16'($urandom), 16'($urandom),
                         16'($urandom));
            end
            else
            begin
                // aim into the grid, with a little margin around it
                for (int a = 0; a < 3; a++)
                    c[a] = cur_org[a] + 32'($urandom_range(0, (cur_dim[a] + 1) * cur_edge))
                           - 32'($urandom_range(0, cur_edge));
                probe_at(c[0], c[1], c[2], pick_normal_axis(), pick_normal_axis(),
                         pick_normal_axis());
            end
        end
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset setup has no volume: grid is not read
        cur_org[0] = 0;
        cur_org[1] = 0;
        cur_org[2] = 0;
        cur_edge = 0;
        cur_dim[0] = 0;
        cur_dim[1] = 0;
        cur_dim[2] = 0;
        probe_at(32'h8000_0000, 32'h7fff_ffff, 32'h0, 16'h8000, 16'h7fff, 16'h0);
        probe_at(32'hffff_ffff, 32'h0, 32'h8000_0000, 16'hffff, 16'h0, 16'h8000);

        set_grid(32'h0, 32'h0, 32'h0, 16'd256, 4, 4, 4, 8'd64);
        write_cell(63, 63, 63, 8'hff);
        write_cell(0, 0, 0, 8'h00);
        write_cell(1, 0, 0, 8'hff);
        probe_at(32'd512, 32'd512, 32'd512, 16'sd16384, 16'd0, 16'd0);
        probe_at(32'd512, 32'd512, 32'd512, -16'sd16384, 16'd0, 16'd0);
        probe_at(32'd512, 32'd512, 32'd512, 16'd0, 16'sd16384, 16'd0);
        probe_at(32'd512, 32'd512, 32'd512, 16'd0, 16'd0, -16'sd16384);
        probe_at(32'd100, 32'd900, 32'd300, 16'h8000, 16'h7fff, 16'h8000);
        probe_at(32'h7fff_ffff, 32'h8000_0000, 32'd0, 16'd0, 16'd0, 16'd0);
        probe_at(32'd0, 32'd0, 32'd0, 16'd0, 16'd0, 16'd0);
        probe_at(32'd1023, 32'd1023, 32'd1023, 16'sd9459, 16'sd9459, 16'sd9459);

        // full backpressure: block fills and stalls its input
        sink_hold_req = 1;
        random_traffic(110);

        set_grid(-32'sd1000, 32'sd500, -32'sd20, 16'd1, 8, 3, 2, 8'd0);
        random_traffic(110);

        set_grid(32'h8000_0000, 32'h7fff_ffff, 32'h0, 16'hffff, 64, 2, 2, 8'd255);
        random_traffic(110);

        // dims above the store size saturate
        set_grid(32'sd123, -32'sd456, 32'sd789, 16'd300, 127, 1, 3, 8'd128);
        random_traffic(110);

        set_grid(32'($urandom_range(0, 4000)) - 2000, 32'($urandom_range(0, 4000)) - 2000,
                 32'($urandom_range(0, 4000)) - 2000, 16'($urandom_range(16, 1024)),
                 5, 6, 7, 8'($urandom));
        random_traffic(110);

        // one dimension zero: no volume again
        set_grid(32'h0, 32'h0, 32'h0, 16'd256, 4, 0, 4, 8'd64);
        random_traffic(40);

        sink_steady = 1;
        src_steady = 1;
        set_grid(32'sd64, 32'sd64, 32'sd64, 16'd128, 3, 3, 3, 8'd100);
        random_traffic(60);

        wait_idle();
        repeat (500) @(posedge clk);
        $display("covered %0d requests and %0d probe results over 8 grid setups,",
                 requests_sent, probes_done);
        $display("including no-volume, saturated dims, backpressure and extreme fields");
        if (fails == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

@@ sim.f @@
src/vnrp_pkg.sv
src/vnrp_grid.sv
src/vnrp_div.sv
src/voxel_normal_ray_probe.sv
tb/vnrp_result_checker.sv
tb/voxel_normal_ray_probe_tb.sv
